FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the escape finder.
// No dependencies; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define UVES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define UVES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/uves_pkg.sv
// Package of the escape finder: command codes, FSM states, control structs
// and constants. No dependencies.
`default_nettype none

package uves_pkg;

  localparam int BITMAP_BITS_DEF = 4096;
  localparam int WORD_W          = 31;
  localparam int CMD_W           = 2;
  localparam int ROW_BITS        = 64;
  localparam int ROW_SHIFT       = 6;
  localparam int ROW_IDX_W       = 6;

  localparam logic [WORD_W-1:0] FORBIDDEN_WORD = 31'h7FFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK = 2'd0,
    CMD_FIND = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_DRAIN,
    ST_FOUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;         // latch input word
    logic sweep;       // read and zero the row at the sweep counter
    logic scan_start;  // reset the first-zero search
    logic scan_rd;     // sweep read feeds the search
    logic mark_wr;     // write back the marked row
    logic load_sub;    // load output with substituted word
    logic load_find;   // load output with escape, keep it
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic out_full;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/uves_datapath.sv
// Datapath of the escape finder: bitmap memory, sweep counter, first-zero
// search, escape register and output register. Uses uves_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module uves_datapath #(
  parameter int BITMAP_BITS = uves_pkg::BITMAP_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire uves_pkg::dp_cmd_t           cmd_i,
  output uves_pkg::dp_sts_t                sts_o,
  input  wire logic [uves_pkg::WORD_W-1:0] in_word,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [uves_pkg::WORD_W-1:0]      out_result_word,
  output logic                             out_result_kind,
  output logic                             out_found
);

  localparam int RowW = uves_pkg::ROW_BITS;
  localparam int Rows = (BITMAP_BITS + uves_pkg::ROW_BITS - 1) / uves_pkg::ROW_BITS;
  localparam int RowAW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int PosW = $clog2(BITMAP_BITS + 1);
  localparam int IdxW = uves_pkg::ROW_IDX_W;

  logic [RowW-1:0]               mem [Rows];
  logic [RowW-1:0]               rd_data_r;
  logic [RowAW-1:0]              rd_row_r;
  logic [RowAW-1:0]              raddr;
  logic [RowAW-1:0]              waddr;
  logic [RowW-1:0]               wdata;
  logic                          we;
  logic [RowAW-1:0]              cnt_r;
  logic                          cnt_last;
  logic [uves_pkg::WORD_W-1:0]   word_r;
  logic                          in_range;
  logic                          pend_r;
  logic                          hit_r;
  logic [PosW-1:0]               pos_r;
  logic [uves_pkg::WORD_W-1:0]   escape_r;
  logic [uves_pkg::WORD_W-1:0]   sub_word;
  logic [RowW-1:0]               inv;
  logic [RowW-1:0]               low;
  logic [IdxW-1:0]               zidx;
  logic                          zero_any;
  logic                          out_valid_r;
  logic [uves_pkg::WORD_W-1:0]   out_word_r;
  logic                          out_kind_r;
  logic                          out_found_r;

  assign cnt_last = (cnt_r == RowAW'(Rows - 1));
  assign in_range = (word_r < uves_pkg::WORD_W'(BITMAP_BITS));

  // sweep rows during reset clear and find; otherwise read the row of the
  // incoming word so a mark can write it back in the next cycle
  assign raddr = cmd_i.sweep ? cnt_r : in_word[uves_pkg::ROW_SHIFT +: RowAW];
  assign waddr = cmd_i.sweep ? cnt_r : word_r[uves_pkg::ROW_SHIFT +: RowAW];
  assign wdata = cmd_i.sweep ? '0
                 : (rd_data_r | (RowW'(1) << word_r[IdxW-1:0]));
  assign we    = cmd_i.sweep | (cmd_i.mark_wr & in_range);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
    rd_row_r  <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd_i.scan_rd;
      if (cmd_i.sweep) begin
        cnt_r <= cnt_last ? '0 : cnt_r + RowAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      word_r <= in_word;
    end
  end

  // lowest clear bit of the row: isolate it, then encode the one-hot
  always_comb begin
    inv      = ~rd_data_r;
    low      = inv & (~inv + RowW'(1));
    zero_any = |inv;
    zidx     = '0;
    for (int i = 0; i < RowW; i++) begin
      if (low[i]) begin
        zidx = zidx | IdxW'(i);
      end
    end
  end

  // bits past the end of a partial last row are never marked, so a full
  // map lands on BITMAP_BITS itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd_i.scan_start) begin
      hit_r <= 1'b0;
    end else if (pend_r && !hit_r && zero_any) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.scan_start) begin
      pos_r <= PosW'(BITMAP_BITS);
    end else if (pend_r && !hit_r && zero_any) begin
      pos_r <= PosW'({rd_row_r, zidx});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= '0;
    end else if (cmd_i.load_find) begin
      escape_r <= uves_pkg::WORD_W'(pos_r);
    end
  end

  assign sub_word = (in_word == uves_pkg::FORBIDDEN_WORD) ? escape_r : in_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_find || cmd_i.load_sub) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_find) begin
      out_word_r  <= uves_pkg::WORD_W'(pos_r);
      out_kind_r  <= 1'b0;
      out_found_r <= (pos_r < PosW'(BITMAP_BITS));
    end else if (cmd_i.load_sub) begin
      out_word_r  <= sub_word;
      out_kind_r  <= 1'b1;
      out_found_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_result_kind = out_kind_r;
  assign out_found       = out_found_r;

  assign sts_o.cnt_last = cnt_last;
  assign sts_o.out_full = out_valid_r;

  `UVES_ASSERT(a_no_overwrite, clk, rst_n, (cmd_i.load_find || cmd_i.load_sub) |-> (!out_valid_r || out_ready), "output loaded over an untaken transaction")
  `UVES_ASSERT(a_mark_after_cap, clk, rst_n, cmd_i.mark_wr |-> $past(cmd_i.cap), "mark write without a captured word")
  `UVES_ASSERT(a_escape_kept, clk, rst_n, $past(cmd_i.load_find) |-> (escape_r == out_word_r), "kept escape differs from reported escape")

endmodule

`default_nettype wire

FILE: rtl/uves_ctrl.sv
// Controller of the escape finder: sequences reset clear, mark, find and
// substitute. Uses uves_pkg.
`default_nettype none

module uves_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [uves_pkg::CMD_W-1:0] in_cmd,
  input  wire logic                       out_ready,
  input  wire uves_pkg::dp_sts_t          sts_i,
  output uves_pkg::dp_cmd_t               cmd_o
);

  uves_pkg::state_t state_r;
  uves_pkg::state_t state_nxt;
  logic             acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uves_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    acc       = 1'b0;
    unique case (state_r)
      uves_pkg::ST_CLR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.cnt_last) begin
          state_nxt = uves_pkg::ST_IDLE;
        end
      end
      uves_pkg::ST_IDLE: begin
        // a waiting result holds off every command until it is taken
        in_ready  = !sts_i.out_full || out_ready;
        acc       = in_valid && in_ready;
        cmd_o.cap = acc;
        if (acc) begin
          unique case (uves_pkg::cmd_t'(in_cmd))
            uves_pkg::CMD_MARK: state_nxt = uves_pkg::ST_MARK;
            uves_pkg::CMD_FIND: begin
              cmd_o.scan_start = 1'b1;
              state_nxt        = uves_pkg::ST_SCAN;
            end
            uves_pkg::CMD_SUB:  cmd_o.load_sub = 1'b1;
            default:            state_nxt = uves_pkg::ST_IDLE;
          endcase
        end
      end
      uves_pkg::ST_MARK: begin
        cmd_o.mark_wr = 1'b1;
        state_nxt     = uves_pkg::ST_IDLE;
      end
      uves_pkg::ST_SCAN: begin
        cmd_o.sweep   = 1'b1;
        cmd_o.scan_rd = 1'b1;
        if (sts_i.cnt_last) begin
          state_nxt = uves_pkg::ST_DRAIN;
        end
      end
      uves_pkg::ST_DRAIN: begin
        state_nxt = uves_pkg::ST_FOUT;
      end
      uves_pkg::ST_FOUT: begin
        cmd_o.load_find = 1'b1;
        state_nxt       = uves_pkg::ST_IDLE;
      end
      default: state_nxt = uves_pkg::ST_CLR;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/unused_value_escape_substitution_top.sv
// Escape finder with word substitution. Input channel in_* takes commands:
// mark a word (0), find the smallest unmarked value and clear (1), substitute
// 0x7FFFFFFF in a word by the kept escape (2); 3 does nothing.
// Output channel out_* returns one transaction for find and substitute.
// The bitmap is a memory of ceil(BITMAP_BITS/64) rows of 64 bits.
// Mark: read row, then write row back (in_ready low meanwhile); no result.
// Substitute: result valid the cycle after acceptance.
// Find: SCAN walks the rows over the single memory read port, zeroing each row
// as it is read; then DRAIN, then FOUT loads the result. in_ready stays low
// until the controller is back in IDLE.
// After reset a clearing pass zeroes the bitmap row by row with in_ready low;
// the escape starts at zero.
// A result waits in the output register while out_ready is low. No command
// is accepted then; in_ready returns in the cycle that out_ready is high.
// Uses uves_pkg, uves_ctrl, uves_datapath.
`default_nettype none

module unused_value_escape_substitution_top #(
  parameter int BITMAP_BITS = uves_pkg::BITMAP_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [uves_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [uves_pkg::WORD_W-1:0] in_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [uves_pkg::WORD_W-1:0]      out_result_word,
  output logic                             out_result_kind,
  output logic                             out_found
);

  uves_pkg::dp_cmd_t dp_cmd;
  uves_pkg::dp_sts_t dp_sts;

  uves_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_ready (out_ready),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  uves_datapath #(
    .BITMAP_BITS (BITMAP_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .in_word         (in_word),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_result_word (out_result_word),
    .out_result_kind (out_result_kind),
    .out_found       (out_found)
  );

endmodule

`default_nettype wire

FILE: tb/tb_unused_value_escape_substitution_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for unused_value_escape_substitution_top: drives mark, find,
// substitute and unused commands and checks every result against an in-file model.
// Depends on uves_pkg and the RTL of the escape finder.
`default_nettype none

module tb_unused_value_escape_substitution_top;

  localparam int BITMAP_BITS   = uves_pkg::BITMAP_BITS_DEF;
  localparam int WORD_W        = uves_pkg::WORD_W;
  localparam int CMD_W         = uves_pkg::CMD_W;
  localparam int ROW_BITS      = uves_pkg::ROW_BITS;
  localparam int MAP_ROWS      = (BITMAP_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int SCAN_CYCLES   = MAP_ROWS + 3;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 200;

  typedef struct packed {
    uves_pkg::cmd_t    cmd;
    logic [WORD_W-1:0] word;
  } cmd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              kind;
    logic              found;
  } result_item_t;

  typedef enum int {FLOW_STEADY, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = uves_pkg::CMD_NONE;
  logic [WORD_W-1:0] in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_result_word;
  logic              out_result_kind;
  logic              out_found;

  cmd_item_t         cmd_backlog[$];
  result_item_t      mex_sub_results[$];
  cmd_item_t         offered_item;
  bit [BITMAP_BITS-1:0] present_map = '0;
  logic [WORD_W-1:0] kept_escape = '0;
  int                queued_count = 0;
  int                accepted_count = 0;
  int                fail_count = 0;
  flow_t             flow = FLOW_STEADY;
  bit                hold_arm = 1'b0;
  logic              sink_hold = 1'b0;

  unused_value_escape_substitution_top #(
    .BITMAP_BITS(BITMAP_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_word(out_result_word),
    .out_result_kind(out_result_kind),
    .out_found(out_found)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Model: marks fill the map, find takes the smallest absent value and clears,
  // substitute swaps the forbidden word for the kept escape.
  task automatic update_mex_model(input cmd_item_t it);
    result_item_t r;
    int pos;
    pos = 0;
    r.word = '0;
    r.kind = 1'b0;
    r.found = 1'b0;
    case (it.cmd)
      uves_pkg::CMD_MARK: if (it.word < BITMAP_BITS) present_map[it.word] = 1'b1;
      uves_pkg::CMD_FIND: begin
        while (pos < BITMAP_BITS && present_map[pos]) pos++;
        kept_escape = pos[WORD_W-1:0];
        present_map = '0;
        r.word = kept_escape;
        r.found = (pos < BITMAP_BITS);
        mex_sub_results.push_back(r);
      end
      uves_pkg::CMD_SUB: begin
        r.word = (it.word == uves_pkg::FORBIDDEN_WORD) ? kept_escape : it.word;
        r.kind = 1'b1;
        mex_sub_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic bit src_gap();
    case (flow)
      FLOW_SRC_GAPS: return $urandom_range(99) < 47;
      FLOW_BOTH:     return $urandom_range(99) < 35;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stall();
    case (flow)
      FLOW_SINK_STALLS: return $urandom_range(99) < 47;
      FLOW_BOTH:        return $urandom_range(99) < 35;
      default:          return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_mex_model(offered_item);
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && !src_gap()) begin
          offered_item = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= offered_item.cmd;
          in_word  <= offered_item.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mex_sub_results.size() == 0) begin
          $error("result transaction with nothing pending: word=%h kind=%0d found=%0d",
                 out_result_word, out_result_kind, out_found);
          fail_count++;
        end else begin
          want = mex_sub_results.pop_front();
          if (out_result_word !== want.word) begin
            $error("result_word: expected %h, got %h", want.word, out_result_word);
            fail_count++;
          end
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
            fail_count++;
          end
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            fail_count++;
          end
        end
      end
      out_ready <= !sink_hold && !sink_stall();
    end
  end

  // Long receiver hold-off: the sender keeps going so the output register fills
  // and the input backs up.
  initial begin
    while (!hold_arm) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    logic [31:0] v;
    v = $urandom;
    return v[WORD_W-1:0];
  endfunction

  task automatic push_cmd(input uves_pkg::cmd_t c, input logic [WORD_W-1:0] w);
    cmd_item_t it;
    it.cmd = c;
    it.word = w;
    cmd_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || mex_sub_results.size() != 0) @(negedge clk);
  endtask

  // One burst of traffic: mostly mark/find/substitute runs, some noise.
  task automatic queue_episode();
    int kind, span, n_subs, n_extra;
    kind = $urandom_range(9);
    if (kind < 7) begin
      span = ($urandom_range(3) == 0) ? $urandom_range(200, 40) : $urandom_range(12);
      for (int i = 0; i < span; i++)
        if ($urandom_range(15) != 0) push_cmd(uves_pkg::CMD_MARK, WORD_W'(i));
      n_extra = $urandom_range(3);
      for (int i = 0; i < n_extra; i++)
        case ($urandom_range(2))
          0: push_cmd(uves_pkg::CMD_MARK, rand_word());
          1: push_cmd(uves_pkg::CMD_MARK,
                      WORD_W'($urandom_range(BITMAP_BITS + 7, BITMAP_BITS - 8)));
          default: push_cmd(uves_pkg::CMD_MARK, WORD_W'($urandom_range(span + 4)));
        endcase
      push_cmd(uves_pkg::CMD_FIND, rand_word());
      n_subs = $urandom_range(6);
      for (int i = 0; i < n_subs; i++)
        push_cmd(uves_pkg::CMD_SUB,
                 ($urandom_range(2) == 0) ? uves_pkg::FORBIDDEN_WORD : rand_word());
    end else begin
      push_cmd(uves_pkg::cmd_t'(CMD_W'($urandom_range(3))),
               ($urandom_range(1) != 0) ? rand_word() : WORD_W'($urandom_range(70)));
    end
  endtask

  task automatic run_random_phase();
    int start_count;
    start_count = queued_count;
    while (queued_count - start_count < RANDOM_ITEMS) queue_episode();
    wait_drained();
  endtask

  initial begin
    @(negedge clk);
    flow = FLOW_STEADY;
    // substitute before any find uses the reset escape of zero
    push_cmd(uves_pkg::CMD_SUB, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_SUB, '0);
    push_cmd(uves_pkg::CMD_SUB, 31'h7FFF_FFFE);
    push_cmd(uves_pkg::CMD_NONE, rand_word());
    push_cmd(uves_pkg::CMD_FIND, '0);
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(0));
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(1));
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(BITMAP_BITS));
    push_cmd(uves_pkg::CMD_MARK, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(3));
    push_cmd(uves_pkg::CMD_FIND, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_SUB, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_SUB, 31'h2AAA_AAAA);
    push_cmd(uves_pkg::CMD_SUB, 31'h5555_5555);
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(BITMAP_BITS - 1));
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(1));
    push_cmd(uves_pkg::CMD_NONE, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_FIND, 31'h5555_5555);
    push_cmd(uves_pkg::CMD_SUB, uves_pkg::FORBIDDEN_WORD);
    push_cmd(uves_pkg::CMD_FIND, 31'h2AAA_AAAA);
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(2));
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(0));
    push_cmd(uves_pkg::CMD_MARK, WORD_W'(1));
    push_cmd(uves_pkg::CMD_FIND, '0);
    push_cmd(uves_pkg::CMD_SUB, uves_pkg::FORBIDDEN_WORD);
    wait_drained();

    hold_arm = 1'b1;
    run_random_phase();
    flow = FLOW_SRC_GAPS;
    run_random_phase();
    flow = FLOW_SINK_STALLS;
    run_random_phase();
    flow = FLOW_BOTH;
    run_random_phase();

    repeat (SCAN_CYCLES) @(posedge clk);
    if (mex_sub_results.size() != 0) begin
      $error("%0d result transactions never arrived", mex_sub_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d transactions accepted", accepted_count, queued_count);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: unused_value_escape_substitution_top.f
+incdir+rtl
rtl/uves_pkg.sv
rtl/uves_datapath.sv
rtl/uves_ctrl.sv
rtl/unused_value_escape_substitution_top.sv
tb/tb_unused_value_escape_substitution_top.sv
